// ----- rtl/ray_sphere_occlusion_test_core_macros.svh -----
// Assertion helpers shared by the RTL files.
`ifndef RAY_SPHERE_OCCLUSION_TEST_CORE_MACROS_SVH
`define RAY_SPHERE_OCCLUSION_TEST_CORE_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define RSO_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A condition in one cycle requires another condition in the next cycle.
`define RSO_ASSERT_NEXT(label, cond, expct, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expct)) else $error(msg);

`endif

// ----- rtl/rso_pkg.sv -----
`default_nettype none
package rso_pkg;
  localparam int FRAC_BITS = 16;

  // Limb size of the wide multiplier and its operand and product widths.
  localparam int LIMB_W = 32;
  localparam int NLIMB = 3;
  localparam int MUL_W = LIMB_W * NLIMB;
  localparam int ROW_W = MUL_W + LIMB_W;
  localparam int PROD_W = 2 * MUL_W;

  // Internal value widths.
  localparam int A_W = 64;
  localparam int H_W = 67;
  localparam int C_W = 68;
  localparam int UV_W = MUL_W + 2;
  localparam int Q_W = PROD_W + 2;

  localparam int EPS_W = 16;
  localparam logic [EPS_W-1:0] EPS_RESET = 16'd7;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  // Register index taken from paddr[2].
  localparam logic REG_HIT_EPSILON = 1'b0;
endpackage
`default_nettype wire

// ----- rtl/rso_mul.sv -----
`default_nettype none
module rso_mul (
  input  logic                        clk,
  input  logic                        en,
  input  logic [rso_pkg::MUL_W-1:0]   a,
  input  logic [rso_pkg::MUL_W-1:0]   b,
  output logic [rso_pkg::PROD_W-1:0]  p
);
  // Three stages: limb products, row sums, final sum.
  logic [2*rso_pkg::LIMB_W-1:0] pp [rso_pkg::NLIMB][rso_pkg::NLIMB];
  logic [rso_pkg::ROW_W-1:0]    row [rso_pkg::NLIMB];
  logic [rso_pkg::ROW_W-1:0]    row_next [rso_pkg::NLIMB];
  logic [rso_pkg::PROD_W-1:0]   p_next;

  always_comb begin
    for (int i = 0; i < rso_pkg::NLIMB; i++) begin
      row_next[i] = '0;
      for (int j = 0; j < rso_pkg::NLIMB; j++) begin
        row_next[i] = row_next[i] + (rso_pkg::ROW_W'(pp[i][j]) << (rso_pkg::LIMB_W * j));
      end
    end
    p_next = '0;
    for (int i = 0; i < rso_pkg::NLIMB; i++) begin
      p_next = p_next + (rso_pkg::PROD_W'(row[i]) << (rso_pkg::LIMB_W * i));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < rso_pkg::NLIMB; i++) begin
        for (int j = 0; j < rso_pkg::NLIMB; j++) begin
          pp[i][j] <= a[i*rso_pkg::LIMB_W +: rso_pkg::LIMB_W]
                    * b[j*rso_pkg::LIMB_W +: rso_pkg::LIMB_W];
        end
        row[i] <= row_next[i];
      end
      p <= p_next;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/ray_sphere_occlusion_test_core.sv -----
`default_nettype none
// Ray-sphere occlusion test. Each transfer carries a ray, a sphere and a
// distance limit in signed fixed point; one transfer comes back per item with
// blocked set when the nearer root of the ray-sphere quadratic lies strictly
// between hit_epsilon and max_distance. All decisions are exact: the square
// root is never taken, the comparisons are made on squared integer values.
// The block takes one item every clock cycle while the output is not
// stalled; the dot products feed a chain of two 96-bit multipliers (three
// stages each). A stall at the output freezes the whole pipeline.
// hit_epsilon lives at address 0 and may only be written while no
// items are in flight.
`include "ray_sphere_occlusion_test_core_macros.svh"
module ray_sphere_occlusion_test_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rso_pkg::PADDR_W-1:0]   paddr,
  input  logic [rso_pkg::PDATA_W-1:0]   pwdata,
  output logic [rso_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [31:0]            ray_origin_x,
  input  logic signed [31:0]            ray_origin_y,
  input  logic signed [31:0]            ray_origin_z,
  input  logic signed [31:0]            ray_dir_x,
  input  logic signed [31:0]            ray_dir_y,
  input  logic signed [31:0]            ray_dir_z,
  input  logic signed [31:0]            sphere_center_x,
  input  logic signed [31:0]            sphere_center_y,
  input  logic signed [31:0]            sphere_center_z,
  input  logic [30:0]                   sphere_radius,
  input  logic [30:0]                   max_distance,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          blocked
);
  localparam int F = rso_pkg::FRAC_BITS;
  localparam int MW = rso_pkg::MUL_W;
  localparam int PW = rso_pkg::PROD_W;
  localparam int UW = rso_pkg::UV_W;
  localparam int NVLD = 12;

  logic en;
  logic [NVLD-1:0] vld;
  logic [rso_pkg::EPS_W-1:0] hit_epsilon;
  logic cfg_wr;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == rso_pkg::REG_HIT_EPSILON);
  always_comb begin
    prdata = '0;
    if (paddr[2] == rso_pkg::REG_HIT_EPSILON) begin
      prdata = rso_pkg::PDATA_W'(hit_epsilon);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_epsilon <= rso_pkg::EPS_RESET;
    end else if (cfg_wr) begin
      hit_epsilon <= pwdata[rso_pkg::EPS_W-1:0];
    end
  end

  assign en = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld <= {vld[NVLD-2:0], in_valid};
      out_valid <= vld[NVLD-1];
    end
  end

  // Stage 1: offset from ray origin to sphere center.
  logic signed [31:0] d1 [3];
  logic signed [32:0] oc1 [3];
  logic [30:0] r1, m1;

  always_ff @(posedge clk) begin
    if (en) begin
      d1[0] <= ray_dir_x;
      d1[1] <= ray_dir_y;
      d1[2] <= ray_dir_z;
      oc1[0] <= 33'(sphere_center_x) - 33'(ray_origin_x);
      oc1[1] <= 33'(sphere_center_y) - 33'(ray_origin_y);
      oc1[2] <= 33'(sphere_center_z) - 33'(ray_origin_z);
      r1 <= sphere_radius;
      m1 <= max_distance;
    end
  end

  // Stage 2: component products.
  logic signed [63:0] dd_c [3];
  logic signed [64:0] doc_c [3];
  logic signed [65:0] oo_c [3];
  logic [61:0] rr_c;
  logic [63:0] dd2 [3];
  logic signed [64:0] doc2 [3];
  logic [64:0] oo2 [3];
  logic [61:0] rr2;
  logic [30:0] m2;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dd_c[i] = d1[i] * d1[i];
      doc_c[i] = d1[i] * oc1[i];
      oo_c[i] = oc1[i] * oc1[i];
    end
    rr_c = r1 * r1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dd2[i] <= dd_c[i];
        doc2[i] <= doc_c[i];
        oo2[i] <= oo_c[i][64:0];
      end
      rr2 <= rr_c;
      m2 <= m1;
    end
  end

  // Stage 3: a = D.D, h = D.oc (b = 2h), c = oc.oc - R*R.
  logic [rso_pkg::A_W-1:0] a3;
  logic signed [rso_pkg::H_W-1:0] h3;
  logic signed [rso_pkg::C_W-1:0] c3;
  logic [30:0] m3;

  always_ff @(posedge clk) begin
    if (en) begin
      a3 <= dd2[0] + dd2[1] + dd2[2];
      h3 <= rso_pkg::H_W'(doc2[0]) + rso_pkg::H_W'(doc2[1]) + rso_pkg::H_W'(doc2[2]);
      c3 <= $signed({3'b000, oo2[0]}) + $signed({3'b000, oo2[1]})
          + $signed({3'b000, oo2[2]}) - $signed({6'b000000, rr2});
      m3 <= m2;
    end
  end

  // Stage 4: magnitudes for the wide multipliers.
  logic [rso_pkg::H_W-1:0] habs_c;
  logic [rso_pkg::C_W-1:0] cabs_c;
  logic [MW-1:0] hmag4, cmag4, a4, m4, eps_mul;
  logic signed [rso_pkg::H_W-1:0] h4;
  logic signed [rso_pkg::C_W-1:0] c4;
  logic az4;

  assign habs_c = h3[rso_pkg::H_W-1] ? rso_pkg::H_W'(-h3) : rso_pkg::H_W'(h3);
  assign cabs_c = c3[rso_pkg::C_W-1] ? rso_pkg::C_W'(-c3) : rso_pkg::C_W'(c3);
  assign eps_mul = MW'(hit_epsilon);

  always_ff @(posedge clk) begin
    if (en) begin
      hmag4 <= MW'(habs_c);
      cmag4 <= MW'(cabs_c);
      a4 <= MW'(a3);
      m4 <= MW'(m3);
      h4 <= h3;
      c4 <= c3;
      az4 <= (a3 == '0);
    end
  end

  // Stages 5 to 7: h*h, a*|c|, a*eps, a*m.
  logic [PW-1:0] hh_p, ac_p, ae_p, am_p;

  rso_mul u_mul_hh (.clk(clk), .en(en), .a(hmag4), .b(hmag4), .p(hh_p));
  rso_mul u_mul_ac (.clk(clk), .en(en), .a(a4), .b(cmag4), .p(ac_p));
  rso_mul u_mul_ae (.clk(clk), .en(en), .a(a4), .b(eps_mul), .p(ae_p));
  rso_mul u_mul_am (.clk(clk), .en(en), .a(a4), .b(m4), .p(am_p));

  logic signed [rso_pkg::H_W-1:0] hd [3];
  logic signed [rso_pkg::C_W-1:0] cd [3];
  logic azd [3];

  always_ff @(posedge clk) begin
    if (en) begin
      hd[0] <= h4;
      cd[0] <= c4;
      azd[0] <= az4;
      for (int i = 1; i < 3; i++) begin
        hd[i] <= hd[i-1];
        cd[i] <= cd[i-1];
        azd[i] <= azd[i-1];
      end
    end
  end

  // Stage 8: q = h*h - a*c (delta / 4), U = h*2^F - a*eps, V = h*2^F - a*m,
  // and the root product test c*2^F <= a*eps.
  logic signed [rso_pkg::Q_W-1:0] q_c, q8;
  logic signed [UW-1:0] hs_c, cs_c, ae_s, am_s, u8, v8;
  logic close8, az8;

  always_comb begin
    if (cd[2][rso_pkg::C_W-1]) begin
      q_c = $signed({2'b00, hh_p}) + $signed({2'b00, ac_p});
    end else begin
      q_c = $signed({2'b00, hh_p}) - $signed({2'b00, ac_p});
    end
    hs_c = UW'(hd[2]) <<< F;
    cs_c = UW'(cd[2]) <<< F;
    ae_s = $signed({1'b0, ae_p[UW-2:0]});
    am_s = $signed({1'b0, am_p[UW-2:0]});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q8 <= q_c;
      u8 <= hs_c - ae_s;
      v8 <= hs_c - am_s;
      close8 <= (cs_c <= ae_s);
      az8 <= azd[2];
    end
  end

  // Stage 9: magnitudes of U and V, scaled q and the early rejections.
  logic [UW-1:0] uabs_c, vabs_c;
  logic [MW-1:0] umag9, vmag9;
  logic [PW-1:0] qs9;
  logic upos9, vneg9, drop9;
  logic q_neg, q_pos;

  assign uabs_c = u8[UW-1] ? UW'(-u8) : UW'(u8);
  assign vabs_c = v8[UW-1] ? UW'(-v8) : UW'(v8);
  assign q_neg = q8[rso_pkg::Q_W-1];
  assign q_pos = !q_neg && (q8 != '0);

  always_ff @(posedge clk) begin
    if (en) begin
      umag9 <= uabs_c[MW-1:0];
      vmag9 <= vabs_c[MW-1:0];
      qs9 <= {q8[PW-1-2*F:0], {(2*F){1'b0}}};
      upos9 <= !u8[UW-1] && (u8 != '0);
      vneg9 <= v8[UW-1];
      drop9 <= az8 || q_neg || (q_pos && close8);
    end
  end

  // Stages 10 to 12: U*U and V*V.
  logic [PW-1:0] uu_p, vv_p;

  rso_mul u_mul_uu (.clk(clk), .en(en), .a(umag9), .b(umag9), .p(uu_p));
  rso_mul u_mul_vv (.clk(clk), .en(en), .a(vmag9), .b(vmag9), .p(vv_p));

  logic [PW-1:0] qsd [3];
  logic upd [3];
  logic vnd [3];
  logic drd [3];

  always_ff @(posedge clk) begin
    if (en) begin
      qsd[0] <= qs9;
      upd[0] <= upos9;
      vnd[0] <= vneg9;
      drd[0] <= drop9;
      for (int i = 1; i < 3; i++) begin
        qsd[i] <= qsd[i-1];
        upd[i] <= upd[i-1];
        vnd[i] <= vnd[i-1];
        drd[i] <= drd[i-1];
      end
    end
  end

  // Stage 13: the nearer root must lie above eps and below max_distance.
  logic low_ok, high_ok;
  assign low_ok = upd[2] && (uu_p > qsd[2]);
  assign high_ok = vnd[2] || (vv_p < qsd[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      blocked <= 1'b0;
    end else if (en) begin
      blocked <= vld[NVLD-1] && !drd[2] && low_ok && high_ok;
    end
  end

  `RSO_ASSERT(a_blocked_needs_valid, !out_valid |-> !blocked, "blocked set without a result")
  `RSO_ASSERT(a_result_from_pipe, $rose(out_valid) |-> $past(vld[NVLD-1]),
              "result appeared without an item in the last stage")
  `RSO_ASSERT_NEXT(a_stall_freezes, !en, $stable(vld) && $stable(blocked),
                   "pipeline moved during a stall")
  `RSO_ASSERT_NEXT(a_eps_write, cfg_wr, hit_epsilon == $past(pwdata[rso_pkg::EPS_W-1:0]),
                   "hit_epsilon write lost")
endmodule
`default_nettype wire

// ----- verif/ray_sphere_occlusion_test_core_tb.sv -----
`timescale 1ns / 1ps
module ray_sphere_occlusion_test_core_tb;

  typedef struct packed {
    logic signed [31:0] org_x, org_y, org_z;
    logic signed [31:0] dir_x, dir_y, dir_z;
    logic signed [31:0] ctr_x, ctr_y, ctr_z;
    logic [30:0] radius;
    logic [30:0] max_dist;
  } ray_item_t;

  localparam int TIMEOUT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 30;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [rso_pkg::PADDR_W-1:0] paddr = '0;
  logic [rso_pkg::PDATA_W-1:0] pwdata = '0;
  logic [rso_pkg::PDATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  ray_item_t cur_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic blocked;

  ray_item_t ray_q[$];
  bit blocked_q[$];
  logic [rso_pkg::EPS_W-1:0] tb_eps = rso_pkg::EPS_RESET;
  bit in_taken = 1'b0;
  int cycle_cnt = 0;
  int mismatch_cnt = 0;
  int hold_left = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  ray_sphere_occlusion_test_core i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .ray_origin_x(cur_item.org_x), .ray_origin_y(cur_item.org_y),
    .ray_origin_z(cur_item.org_z),
    .ray_dir_x(cur_item.dir_x), .ray_dir_y(cur_item.dir_y), .ray_dir_z(cur_item.dir_z),
    .sphere_center_x(cur_item.ctr_x), .sphere_center_y(cur_item.ctr_y),
    .sphere_center_z(cur_item.ctr_z),
    .sphere_radius(cur_item.radius), .max_distance(cur_item.max_dist),
    .out_valid(out_valid), .out_ready(out_ready), .blocked(blocked)
  );

  // Exact occlusion decision: every comparison is squared into integers.
  function automatic bit sphere_blocks(ray_item_t it, logic [rso_pkg::EPS_W-1:0] eps);
    logic signed [255:0] dx, dy, dz, ox, oy, oz, rr, mm, ee, sc;
    logic signed [255:0] qa, qb, qc, disc, bs, d2, u, v;
    bit low_ok, high_ok;
    dx = it.dir_x; dy = it.dir_y; dz = it.dir_z;
    ox = it.ctr_x; ox = ox - it.org_x;
    oy = it.ctr_y; oy = oy - it.org_y;
    oz = it.ctr_z; oz = oz - it.org_z;
    rr = it.radius;
    mm = it.max_dist;
    ee = eps;
    sc = 256'sd1 <<< rso_pkg::FRAC_BITS;
    qa = dx * dx + dy * dy + dz * dz;
    if (qa == 0) return 1'b0;
    qb = 2 * (dx * ox + dy * oy + dz * oz);
    qc = ox * ox + oy * oy + oz * oz - rr * rr;
    disc = qb * qb - 4 * qa * qc;
    if (disc < 0) return 1'b0;
    // With two distinct roots, both must lie on the same side beyond epsilon.
    if (disc > 0 && qc * sc <= ee * qa) return 1'b0;
    bs = qb * sc;
    d2 = disc * sc * sc;
    u = bs - 2 * qa * ee;
    v = bs - 2 * qa * mm;
    low_ok = (u > 0) && (u * u > d2);
    high_ok = (v < 0) || (v * v < d2);
    return low_ok && high_ok;
  endfunction

  function automatic int rnd_signed(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic ray_item_t noise_item();
    ray_item_t it;
    it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
          $urandom, $urandom, $urandom, 31'($urandom), 31'($urandom)};
    return it;
  endfunction

  // A ray aimed near a sphere center, so that hits and near misses dominate.
  function automatic ray_item_t aimed_item();
    ray_item_t it;
    longint tk;
    it.org_x = rnd_signed(1 << 20);
    it.org_y = rnd_signed(1 << 20);
    it.org_z = rnd_signed(1 << 20);
    it.dir_x = rnd_signed(1 << 18);
    it.dir_y = rnd_signed(1 << 18);
    it.dir_z = rnd_signed(1 << 18);
    tk = longint'(rnd_signed(1 << 22));
    it.ctr_x = it.org_x + 32'((longint'(it.dir_x) * tk) >>> 16) + rnd_signed(1 << 16);
    it.ctr_y = it.org_y + 32'((longint'(it.dir_y) * tk) >>> 16) + rnd_signed(1 << 16);
    it.ctr_z = it.org_z + 32'((longint'(it.dir_z) * tk) >>> 16) + rnd_signed(1 << 16);
    it.radius = 31'($urandom_range(0, 1 << 20));
    it.max_dist = 31'($urandom_range(0, 1 << 23));
    return it;
  endfunction

  function automatic ray_item_t make_item(int ox, int dx, int cx, int cy, int r, int m);
    ray_item_t it;
    it = '0;
    it.org_x = ox; it.dir_x = dx; it.ctr_x = cx; it.ctr_y = cy;
    it.radius = 31'(r); it.max_dist = 31'(m);
    return it;
  endfunction

  task automatic write_eps(logic [rso_pkg::EPS_W-1:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {rso_pkg::REG_HIT_EPSILON, 2'b00};
    pwdata <= rso_pkg::PDATA_W'(val);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    tb_eps = val;
  endtask

  task automatic wait_idle();
    while (ray_q.size() != 0 || in_valid || blocked_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_random(int n);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) ray_q.push_back(noise_item());
      else ray_q.push_back(aimed_item());
    end
  endtask

  // Sender: a new item is offered only once the previous transfer is done.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (ray_q.size() != 0 &&
          ((cycle_cnt > 500 && cycle_cnt < 1000) || $urandom_range(0, 99) >= 17)) begin
        cur_item <= ray_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver, with one long hold-off to back the pipeline up.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (cycle_cnt == 250) begin
      hold_left <= 200;
      out_ready <= 1'b0;
    end else begin
      out_ready <= (cycle_cnt > 500 && cycle_cnt < 1000) || $urandom_range(0, 99) >= 17;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (!rst && in_valid && in_ready) begin
      blocked_q.push_back(sphere_blocks(cur_item, tb_eps));
      in_taken = 1'b1;
    end
    if (!rst && out_valid && out_ready) begin
      if (blocked_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result transfer: blocked=%0b", blocked);
      end else begin
        bit want;
        want = blocked_q.pop_front();
        if (blocked !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("blocked mismatch: expected %0b, actual %0b", want, blocked);
        end
      end
    end
    if (cycle_cnt >= TIMEOUT_CYCLES) begin
      $display("ray_sphere_occlusion_test_core_tb NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed cases with the reset epsilon.
    ray_q.push_back(make_item(0, 0, 10 << 16, 0, 1 << 16, 20 << 16));      // zero direction
    ray_q.push_back(make_item(0, 1 << 16, 10 << 16, 0, 1 << 16, 20 << 16)); // clean hit
    ray_q.push_back(make_item(0, 1 << 16, 10 << 16, 0, 1 << 16, 9 << 16));  // hit exactly at limit
    ray_q.push_back(make_item(0, 1 << 16, 10 << 16, 0, 1 << 16, 5 << 16));  // beyond limit
    ray_q.push_back(make_item(0, 1 << 16, 10 << 16, 5 << 16, 1 << 16, 20 << 16)); // miss
    ray_q.push_back(make_item(0, 1 << 16, 5 << 16, 1 << 16, 1 << 16, 20 << 16));  // tangent ahead
    ray_q.push_back(make_item(0, -(1 << 16), 5 << 16, 1 << 16, 1 << 16, 20 << 16)); // tangent behind
    ray_q.push_back(make_item(0, 1 << 16, 1 << 16, 0, 4 << 16, 20 << 16));  // origin inside
    ray_q.push_back(make_item(0, 1 << 16, -(10 << 16), 0, 1 << 16, 20 << 16)); // sphere behind
    ray_q.push_back(make_item(0, 1 << 16, 10 << 16, 0, 0, 20 << 16));       // zero radius
    ray_q.push_back(make_item(0, 1 << 16, 10 << 16, 0, 32'h7fffffff, 32'h7fffffff));
    ray_q.push_back(make_item(0, 1, 2, 0, 1, 32'h7fffffff));                // tiny values
    ray_q.push_back(make_item(32'h80000000, 32'h7fffffff, 32'h7fffffff, 0, 1 << 16, 32'h7fffffff));
    ray_q.push_back(make_item(32'h7fffffff, 32'h80000000, 32'h80000000, 0, 1 << 16, 32'h7fffffff));
    ray_q.push_back({{9{32'h7fffffff}}, 31'h7fffffff, 31'h7fffffff});
    ray_q.push_back({{9{32'h80000000}}, 31'h7fffffff, 31'h0});
    ray_q.push_back({{3{32'h80000000}}, {3{32'h7fffffff}}, {3{32'h7fffffff}}, 31'h0, 31'h7fffffff});
    ray_q.push_back({{3{32'h7fffffff}}, {3{32'h80000000}}, {3{32'h80000000}}, 31'h1, 31'h7fffffff});
    load_random(400);
    wait_idle();

    write_eps('0);
    ray_q.push_back(make_item(0, 1 << 16, 0, 0, 0, 20 << 16));              // grazing at origin
    ray_q.push_back(make_item(0, 1 << 16, 1, 0, 1, 20 << 16));
    load_random(300);
    wait_idle();

    write_eps(16'hffff);
    ray_q.push_back(make_item(0, 1 << 16, 2 << 16, 0, 1 << 16, 20 << 16)); // hit at one unit
    load_random(250);
    wait_idle();

    write_eps(rso_pkg::EPS_W'($urandom));
    load_random(180);
    wait_idle();

    if (mismatch_cnt == 0) begin
      $display("ray_sphere_occlusion_test_core_tb OK");
    end else begin
      $display("ray_sphere_occlusion_test_core_tb NOT OK");
    end
    $finish;
  end
endmodule
